// File: hw/rtl/rlpe_pkg.sv
// Shared types and constants for the single-wire RGB LED pulse encoder.
// Used by the channel interfaces and every RTL module of the block but the command queue; no dependencies.
`default_nettype none

package rlpe_pkg;

   localparam int unsigned DUR_W       = 16;
   localparam int unsigned COLOR_W     = 8;
   localparam int unsigned CSR_INDEX_W = 3;

   // command codes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_LATCH = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_LOW  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_LOW   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LATCH_LOW = 3'd4;

   // register values after reset
   localparam logic [DUR_W-1:0] ZERO_HIGH_RESET = 16'd50;
   localparam logic [DUR_W-1:0] ZERO_LOW_RESET  = 16'd150;
   localparam logic [DUR_W-1:0] ONE_HIGH_RESET  = 16'd100;
   localparam logic [DUR_W-1:0] ONE_LOW_RESET   = 16'd100;
   localparam logic [DUR_W-1:0] LATCH_LOW_RESET = 16'd13333;

   typedef struct packed {
      logic [DUR_W-1:0] zero_high;
      logic [DUR_W-1:0] zero_low;
      logic [DUR_W-1:0] one_high;
      logic [DUR_W-1:0] one_low;
      logic [DUR_W-1:0] latch_low;
   } timing_type;

endpackage

`default_nettype wire

// File: hw/rtl/rlpe_channels.sv
// Valid/ready channel interfaces: command input, segment output, register writes.
// Depends on rlpe_pkg for field widths.
`default_nettype none

interface rlpe_req_if;
   logic                             valid;
   logic                             ready;
   logic                             operation;
   logic [rlpe_pkg::COLOR_W-1:0]     red;
   logic [rlpe_pkg::COLOR_W-1:0]     green;
   logic [rlpe_pkg::COLOR_W-1:0]     blue;

   modport source (output valid, operation, red, green, blue, input ready);
   modport sink   (input valid, operation, red, green, blue, output ready);
endinterface

interface rlpe_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             pin_level;
   logic [rlpe_pkg::DUR_W-1:0]       duration;
   logic                             last_segment;

   modport source (output valid, pin_level, duration, last_segment, input ready);
   modport sink   (input valid, pin_level, duration, last_segment, output ready);
endinterface

interface rlpe_csr_if;
   logic                             valid;
   logic                             ready;
   logic [rlpe_pkg::CSR_INDEX_W-1:0] index;
   logic [rlpe_pkg::DUR_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rlpe_cfg_regs.sv
// Segment timing registers, written through the register write channel.
// Depends on rlpe_pkg and rlpe_csr_if.
`default_nettype none

module rlpe_cfg_regs (
   input  wire logic          clock,
   input  wire logic          reset,
   rlpe_csr_if.sink           csr_chan,
   output rlpe_pkg::timing_type timing
);

   rlpe_pkg::timing_type timing_ff;

   assign csr_chan.ready = 1'b1;
   assign timing         = timing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.zero_high <= rlpe_pkg::ZERO_HIGH_RESET;
         timing_ff.zero_low  <= rlpe_pkg::ZERO_LOW_RESET;
         timing_ff.one_high  <= rlpe_pkg::ONE_HIGH_RESET;
         timing_ff.one_low   <= rlpe_pkg::ONE_LOW_RESET;
         timing_ff.latch_low <= rlpe_pkg::LATCH_LOW_RESET;
      end else if (csr_chan.valid) begin
         // drop writes to unknown indexes
         case (csr_chan.index)
            rlpe_pkg::CSR_ZERO_HIGH: timing_ff.zero_high <= csr_chan.data;
            rlpe_pkg::CSR_ZERO_LOW:  timing_ff.zero_low  <= csr_chan.data;
            rlpe_pkg::CSR_ONE_HIGH:  timing_ff.one_high  <= csr_chan.data;
            rlpe_pkg::CSR_ONE_LOW:   timing_ff.one_low   <= csr_chan.data;
            rlpe_pkg::CSR_LATCH_LOW: timing_ff.latch_low <= csr_chan.data;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/rlpe_front.sv
// Command front end: accepts items, classifies them and packs pixel bits for the queue.
// Depends on rlpe_pkg and rlpe_req_if.
`default_nettype none

module rlpe_front #(
   parameter int unsigned COLOR_BITS = 8
) (
   rlpe_req_if.sink                  req_chan,
   input  wire logic                 queue_full,
   output logic                      push,
   output logic                      push_op,
   output logic [3*COLOR_BITS-1:0]   push_word
);

   logic [COLOR_BITS+rlpe_pkg::COLOR_W-1:0] green_wide;
   logic [COLOR_BITS+rlpe_pkg::COLOR_W-1:0] red_wide;
   logic [COLOR_BITS+rlpe_pkg::COLOR_W-1:0] blue_wide;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;
   assign push_op        = req_chan.operation;

   // zero-extend, then keep the low COLOR_BITS of each color
   assign green_wide = {{COLOR_BITS{1'b0}}, req_chan.green};
   assign red_wide   = {{COLOR_BITS{1'b0}}, req_chan.red};
   assign blue_wide  = {{COLOR_BITS{1'b0}}, req_chan.blue};

   always_comb begin
      if (req_chan.operation == rlpe_pkg::OP_PIXEL) begin
         push_word = {green_wide[COLOR_BITS-1:0], red_wide[COLOR_BITS-1:0],
                      blue_wide[COLOR_BITS-1:0]};
      end else begin
         push_word = '0;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/rlpe_cmd_fifo.sv
// Two-entry command queue between the front end and the segment serializer.
// No package dependencies.
`default_nettype none

module rlpe_cmd_fifo #(
   parameter int unsigned WIDTH = 25
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  not_empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("command queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full command queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/rlpe_back.sv
// Segment serializer: turns queued commands into high/low segments, one per cycle while the output is not stalled.
// Depends on rlpe_pkg and rlpe_rsp_if.
`default_nettype none

module rlpe_back #(
   parameter int unsigned COLOR_BITS = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rlpe_pkg::timing_type    timing,
   input  wire logic                    cmd_valid,
   input  wire logic                    cmd_op,
   input  wire logic [3*COLOR_BITS-1:0] cmd_word,
   output logic                         cmd_pop,
   rlpe_rsp_if.source                   rsp_chan
);

   localparam int unsigned TOTAL = 3 * COLOR_BITS;
   localparam int unsigned CNT_W = $clog2(TOTAL);

   logic                      active_ff, active_in;
   logic [TOTAL-1:0]          shift_ff, shift_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      phase_ff, phase_in;
   logic                      out_valid_ff;
   logic                      out_level_ff;
   logic [rlpe_pkg::DUR_W-1:0] out_dur_ff;
   logic                      out_last_ff;

   logic                      cur_op;
   logic [TOTAL-1:0]          cur_shift;
   logic [CNT_W-1:0]          cur_cnt;
   logic                      cur_phase;
   logic                      cur_bit;
   logic                      advance;
   logic                      seg_level;
   logic [rlpe_pkg::DUR_W-1:0] seg_dur;
   logic                      seg_last;

   // work straight off the queue head when idle, so no bubble between commands
   assign cur_op    = active_ff ? rlpe_pkg::OP_PIXEL : cmd_op;
   assign cur_shift = active_ff ? shift_ff : cmd_word;
   assign cur_cnt   = active_ff ? cnt_ff : '0;
   assign cur_phase = active_ff ? phase_ff : 1'b0;
   assign cur_bit   = cur_shift[TOTAL-1];

   assign advance = (active_ff || cmd_valid) && (!out_valid_ff || rsp_chan.ready);
   assign cmd_pop = advance && !active_ff;

   always_comb begin
      if (cur_op == rlpe_pkg::OP_LATCH) begin
         seg_level = 1'b0;
         seg_dur   = timing.latch_low;
         seg_last  = 1'b1;
      end else if (!cur_phase) begin
         seg_level = 1'b1;
         seg_dur   = cur_bit ? timing.one_high : timing.zero_high;
         seg_last  = 1'b0;
      end else begin
         seg_level = 1'b0;
         seg_dur   = cur_bit ? timing.one_low : timing.zero_low;
         seg_last  = (cur_cnt == CNT_W'(TOTAL - 1));
      end
   end

   always_comb begin
      active_in = active_ff;
      shift_in  = shift_ff;
      cnt_in    = cnt_ff;
      phase_in  = phase_ff;
      if (advance) begin
         active_in = !seg_last;
         if (cur_phase) begin
            // low segment done: advance to the next bit
            shift_in = {cur_shift[TOTAL-2:0], 1'b0};
            cnt_in   = cur_cnt + CNT_W'(1);
            phase_in = 1'b0;
         end else begin
            shift_in = cur_shift;
            cnt_in   = cur_cnt;
            phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cnt_ff       <= '0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         phase_ff  <= phase_in;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (advance) begin
         out_level_ff <= seg_level;
         out_dur_ff   <= seg_dur;
         out_last_ff  <= seg_last;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.pin_level    = out_level_ff;
   assign rsp_chan.duration     = out_dur_ff;
   assign rsp_chan.last_segment = out_last_ff;

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (cnt_ff < CNT_W'(TOTAL)))
      else $error("bit counter past end of pixel");
   a_last_ends_cmd: assert property (@(posedge clock) disable iff (reset)
      (advance && seg_last) |=> !active_ff)
      else $error("serializer still busy after last segment");
   a_mid_keeps_cmd: assert property (@(posedge clock) disable iff (reset)
      (advance && !seg_last) |=> active_ff)
      else $error("serializer dropped a command mid-pixel");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/rgb_led_pulse_encoder_unit.sv
// Single-wire RGB LED pulse encoder, top level.
// The first segment of an item passes the command queue and the serializer's output register before it is valid.
// A pixel item becomes 6*COLOR_BITS segments (48 by default), a latch item one; the serializer
// emits one segment per cycle while the output is not stalled, and a 2-entry queue feeds it.
// Reset (synchronous, active high): timing registers to defaults, queue and output empty.
// Depends on rlpe_pkg, the channel interfaces and the rlpe_* modules.
`default_nettype none

module rgb_led_pulse_encoder_unit #(
   parameter int unsigned COLOR_BITS = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rlpe_req_if.sink    req_chan,
   rlpe_rsp_if.source  rsp_chan,
   rlpe_csr_if.sink    csr_chan
);

   localparam int unsigned WORD_W = 3 * COLOR_BITS;

   rlpe_pkg::timing_type timing;
   logic                 push;
   logic                 push_op;
   logic [WORD_W-1:0]    push_word;
   logic                 queue_full;
   logic                 queue_pop;
   logic [WORD_W:0]      queue_head;
   logic                 queue_not_empty;

   rlpe_cfg_regs u_cfg (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .timing   (timing)
   );

   rlpe_front #(.COLOR_BITS(COLOR_BITS)) u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_op    (push_op),
      .push_word  (push_word)
   );

   rlpe_cmd_fifo #(.WIDTH(WORD_W + 1)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_op, push_word}),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (queue_head),
      .not_empty (queue_not_empty)
   );

   rlpe_back #(.COLOR_BITS(COLOR_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .timing    (timing),
      .cmd_valid (queue_not_empty),
      .cmd_op    (queue_head[WORD_W]),
      .cmd_word  (queue_head[WORD_W-1:0]),
      .cmd_pop   (queue_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// File: tb/rgb_led_pulse_encoder_unit_checker.sv
// Scoreboard for the RGB LED pulse encoder: watches the command, segment and register channels,
// predicts every segment from its own copy of the timing registers and compares field by field.
// Depends on rlpe_pkg for widths, command codes and register indexes.

module rgb_led_pulse_encoder_unit_checker #(
   parameter int unsigned COLOR_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_operation,
   input  logic [rlpe_pkg::COLOR_W-1:0]        req_red,
   input  logic [rlpe_pkg::COLOR_W-1:0]        req_green,
   input  logic [rlpe_pkg::COLOR_W-1:0]        req_blue,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_pin_level,
   input  logic [rlpe_pkg::DUR_W-1:0]          rsp_duration,
   input  logic                                rsp_last_segment,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [rlpe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rlpe_pkg::DUR_W-1:0]          csr_data,
   output int                                  failures,
   output int                                  segments_seen,
   output int                                  segments_pending
);

   import rlpe_pkg::*;

   typedef struct packed {
      logic             pin_level;
      logic [DUR_W-1:0] duration;
      logic             last_segment;
   } segment_type;

   segment_type segments_due[$];
   timing_type  timing_q;

   task automatic report_mismatch(input string what);
      $display("[%0t] segment %0d: %s", $realtime, segments_seen, what);
      failures++;
   endtask

   // Expand one command into its line segments: green, red, blue, MSB first.
   function automatic void encode_command(input logic op, input logic [COLOR_W-1:0] red,
                                          input logic [COLOR_W-1:0] green,
                                          input logic [COLOR_W-1:0] blue);
      segment_type        seg;
      logic [COLOR_W-1:0] colors [3];
      logic               one;
      if (op == OP_LATCH) begin
         seg.pin_level    = 1'b0;
         seg.duration     = timing_q.latch_low;
         seg.last_segment = 1'b1;
         segments_due.push_back(seg);
         return;
      end
      colors[0] = green;
      colors[1] = red;
      colors[2] = blue;
      for (int c = 0; c < 3; c++) begin
         for (int k = int'(COLOR_BITS) - 1; k >= 0; k--) begin
            // bits above the byte go out as zero bits
            one = (k < int'(COLOR_W)) ? colors[c][k] : 1'b0;
            seg.pin_level    = 1'b1;
            seg.duration     = one ? timing_q.one_high : timing_q.zero_high;
            seg.last_segment = 1'b0;
            segments_due.push_back(seg);
            seg.pin_level    = 1'b0;
            seg.duration     = one ? timing_q.one_low : timing_q.zero_low;
            seg.last_segment = (c == 2) && (k == 0);
            segments_due.push_back(seg);
         end
      end
   endfunction

   // Sample mid-cycle: every channel changes only at the rising edge.
   always @(negedge clock) begin
      segment_type want;
      if (reset) begin
         timing_q.zero_high = ZERO_HIGH_RESET;
         timing_q.zero_low  = ZERO_LOW_RESET;
         timing_q.one_high  = ONE_HIGH_RESET;
         timing_q.one_low   = ONE_LOW_RESET;
         timing_q.latch_low = LATCH_LOW_RESET;
         segments_due.delete();
         failures      = 0;
         segments_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ZERO_HIGH: timing_q.zero_high = csr_data;
               CSR_ZERO_LOW:  timing_q.zero_low  = csr_data;
               CSR_ONE_HIGH:  timing_q.one_high  = csr_data;
               CSR_ONE_LOW:   timing_q.one_low   = csr_data;
               CSR_LATCH_LOW: timing_q.latch_low = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (segments_due.size() == 0) begin
               report_mismatch($sformatf("unexpected segment level %b duration %0d last %b",
                                         rsp_pin_level, rsp_duration, rsp_last_segment));
            end else begin
               want = segments_due.pop_front();
               if (rsp_pin_level !== want.pin_level)
                  report_mismatch($sformatf("pin_level %b, expected %b",
                                            rsp_pin_level, want.pin_level));
               if (rsp_duration !== want.duration)
                  report_mismatch($sformatf("duration %0d, expected %0d",
                                            rsp_duration, want.duration));
               if (rsp_last_segment !== want.last_segment)
                  report_mismatch($sformatf("last_segment %b, expected %b",
                                            rsp_last_segment, want.last_segment));
               segments_seen++;
            end
         end
         if (req_valid && req_ready) begin
            encode_command(req_operation, req_red, req_green, req_blue);
         end
      end
      segments_pending = segments_due.size();
   end

endmodule

// File: tb/rgb_led_pulse_encoder_unit_tb.sv
// Testbench top for the RGB LED pulse encoder: drives commands and timing register writes
// under several flow-control mixes and reports the verdict.
// Depends on rlpe_pkg, the channel interfaces, the block and its checker.

module rgb_led_pulse_encoder_unit_tb;

   import rlpe_pkg::*;

   localparam int unsigned COLOR_BITS    = 8;
   localparam int          LIMIT_CYCLES  = 1000000;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          QUIET_CYCLES  = 8;
   localparam int          RANDOM_PHASES = 6;
   localparam int          PHASE_ITEMS   = 70;

   // indexes past the last timing register; writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_FIRST = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LAST  = 3'd7;

   logic clock = 1'b0;
   logic reset;
   logic hold_arm;
   int   hold_left;
   int   idle_pct;
   int   stall_pct;
   int   cycle_count;
   int   failures;
   int   segments_seen;
   int   segments_pending;
   int   pixels_sent;
   int   latches_sent;
   int   settings_used;

   rlpe_req_if req_bus ();
   rlpe_rsp_if rsp_bus ();
   rlpe_csr_if csr_bus ();

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   rgb_led_pulse_encoder_unit #(
      .COLOR_BITS (COLOR_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   rgb_led_pulse_encoder_unit_checker #(
      .COLOR_BITS (COLOR_BITS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_ready        (req_bus.ready),
      .req_operation    (req_bus.operation),
      .req_red          (req_bus.red),
      .req_green        (req_bus.green),
      .req_blue         (req_bus.blue),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_pin_level    (rsp_bus.pin_level),
      .rsp_duration     (rsp_bus.duration),
      .rsp_last_segment (rsp_bus.last_segment),
      .csr_valid        (csr_bus.valid),
      .csr_ready        (csr_bus.ready),
      .csr_index        (csr_bus.index),
      .csr_data         (csr_bus.data),
      .failures         (failures),
      .segments_seen    (segments_seen),
      .segments_pending (segments_pending)
   );

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d segments outstanding", cycle_count,
               segments_pending);
      $display("rgb_led_pulse_encoder_unit regression: fail");
      $finish;
   end

   // Hold-off counter: a pulse on hold_arm stalls the receiver until the counter, loaded with HOLD_CYCLES, runs down.
   initial begin
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end else if (hold_arm) begin
            hold_left <= HOLD_CYCLES;
         end
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_command(input logic op, input logic [COLOR_W-1:0] red,
                               input logic [COLOR_W-1:0] green,
                               input logic [COLOR_W-1:0] blue);
      logic taken;
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.red       <= red;
      req_bus.green     <= green;
      req_bus.blue      <= blue;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
      if (op == OP_LATCH) latches_sent++;
      else pixels_sent++;
   endtask

   // Leaves valid high; the caller drops it once the burst of writes is done.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [DUR_W-1:0] data);
      logic taken;
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do begin
         @(negedge clock);
         taken = csr_bus.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Always wait on the clock while idle before checking, so the next drive lands in a later step.
   task automatic drain_segments;
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (segments_pending != 0);
   endtask

   task automatic apply_timing(input logic [DUR_W-1:0] zero_high, input logic [DUR_W-1:0] zero_low,
                               input logic [DUR_W-1:0] one_high, input logic [DUR_W-1:0] one_low,
                               input logic [DUR_W-1:0] latch_low);
      drain_segments();
      repeat (QUIET_CYCLES) @(posedge clock);
      write_register(CSR_ZERO_HIGH, zero_high);
      write_register(CSR_ZERO_LOW, zero_low);
      write_register(CSR_ONE_HIGH, one_high);
      write_register(CSR_ONE_LOW, one_low);
      write_register(CSR_LATCH_LOW, latch_low);
      write_register(CSR_INDEX_W'($urandom_range(CSR_UNUSED_LAST, CSR_UNUSED_FIRST)),
                     DUR_W'($urandom));
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [DUR_W-1:0] pick_duration();
      case ($urandom_range(7))
         0:       return '0;
         1:       return DUR_W'(1);
         2:       return '1;
         default: return DUR_W'($urandom);
      endcase
   endfunction

   function automatic logic [COLOR_W-1:0] pick_color();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         default: return COLOR_W'($urandom);
      endcase
   endfunction

   initial begin
      logic op;
      reset             <= 1'b1;
      hold_arm          <= 1'b0;
      stall_pct         <= 0;
      idle_pct          = 0;
      pixels_sent       = 0;
      latches_sent      = 0;
      settings_used     = 1;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_PIXEL;
      req_bus.red       <= '0;
      req_bus.green     <= '0;
      req_bus.blue      <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= CSR_ZERO_HIGH;
      csr_bus.data      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // timing registers at their reset values
      send_command(OP_PIXEL, 8'h00, 8'h00, 8'h00);
      send_command(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_command(OP_PIXEL, 8'hAA, 8'h55, 8'h0F);
      send_command(OP_PIXEL, 8'h80, 8'h01, 8'h00);
      send_command(OP_PIXEL, 8'h01, 8'h80, 8'h7E);
      send_command(OP_LATCH, 8'hFF, 8'hFF, 8'hFF);
      send_command(OP_LATCH, 8'h00, 8'h00, 8'h00);
      send_command(OP_PIXEL, 8'h55, 8'hAA, 8'hF0);
      send_command(OP_LATCH, 8'h5A, 8'hA5, 8'h3C);

      // extreme durations, a zero-length latch
      apply_timing(16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0);
      send_command(OP_PIXEL, 8'hFF, 8'h00, 8'hFF);
      send_command(OP_PIXEL, 8'h00, 8'hFF, 8'h00);
      send_command(OP_LATCH, 8'h00, 8'h00, 8'h00);
      send_command(OP_PIXEL, 8'hC3, 8'h3C, 8'h81);
      send_command(OP_LATCH, 8'hFF, 8'hFF, 8'hFF);

      // the opposite corners, zero-length low and one-high segments
      apply_timing(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
      send_command(OP_PIXEL, 8'h0F, 8'hF0, 8'h96);
      send_command(OP_LATCH, 8'h12, 8'h34, 8'h56);
      send_command(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_command(OP_PIXEL, 8'h00, 8'h00, 8'h00);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_timing(pick_duration(), pick_duration(), pick_duration(), pick_duration(),
                      pick_duration());
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 77; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 77; end
            default: begin idle_pct = 12; stall_pct <= 12; end
         endcase
         if (phase == 0) begin
            // stall the output while commands keep coming so the input backs up
            hold_arm <= 1'b1;
            @(posedge clock);
            hold_arm <= 1'b0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(39) == 0) drain_segments();
            op = ($urandom_range(4) == 0) ? OP_LATCH : OP_PIXEL;
            send_command(op, pick_color(), pick_color(), pick_color());
         end
      end

      drain_segments();
      repeat (QUIET_CYCLES) @(posedge clock);
      $display("sent %0d pixel and %0d latch commands under %0d timing settings and four flow mixes",
               pixels_sent, latches_sent, settings_used);
      $display("compared %0d segments, %0d mismatches", segments_seen, failures);
      if (failures == 0) begin
         $display("rgb_led_pulse_encoder_unit regression: pass");
      end else begin
         $display("rgb_led_pulse_encoder_unit regression: fail");
      end
      $finish;
   end

endmodule
